### rtl/core/rrd_pkg.sv
// types, constants and helpers shared by the reflect/refract direction unit
package rrd_pkg;

  localparam int unsigned FRAC_BITS = 14;
  localparam int unsigned ONE       = 1 << FRAC_BITS;
  localparam int unsigned HALF      = 1 << (FRAC_BITS - 1);

  // internal widths
  localparam int unsigned RVEC_W = 39;  // reflect vector before normalize
  localparam int unsigned VEC_W  = 50;  // selected vector before normalize
  localparam int unsigned NRM_W  = 30;  // normalized magnitudes, largest in [2^29, 2^30)
  localparam int unsigned NRM_MSB = NRM_W - 1;
  localparam int unsigned POS_W  = $clog2(VEC_W);

  typedef enum logic [1:0] {
    MODE_VEC,   // normalize the computed vector
    MODE_PASS,  // equal indices, incident passes through
    MODE_TIR    // no refracted ray
  } mode_e;

  typedef struct packed {
    logic               opcode;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] incident_x;
    logic signed [15:0] incident_y;
    logic signed [15:0] incident_z;
    logic [15:0]        index_from;
    logic [15:0]        index_to;
  } rrd_in_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic               ray_valid;
  } rrd_out_t;

  // travels alongside the cos_t divider and square root
  typedef struct packed {
    mode_e                   mode;
    logic                    opcode;
    logic [2:0][15:0]        nv;
    logic [2:0][15:0]        iv;
    logic [15:0]             from;
    logic [15:0]             to;
    logic [15:0]             dc;
    logic [2:0][RVEC_W-1:0]  rvec;
  } cos_side_t;

  // travels alongside the length square root and the component dividers
  typedef struct packed {
    mode_e                  mode;
    logic [2:0][15:0]       iv;
    logic [2:0]             neg;
    logic                   zero;
    logic [2:0][NRM_W-1:0]  m;
  } nrm_side_t;

  localparam opcode_reflect = 1'b0;
  localparam opcode_refract = 1'b1;

  function automatic logic [15:0] sat16(input logic signed [16:0] v);
    logic [15:0] r;
    if (v > 17'sd32767) begin
      r = 16'h7fff;
    end else if (v < -17'sd32768) begin
      r = 16'h8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

### rtl/core/reflect_refract_direction_unit.sv
// reflect / refract direction unit top level
//
//   channel | handshake                  | word
//   --------+----------------------------+-----------------------
//   in      | in_valid_i / in_ready_o    | in_data_i  (rrd_in_t)
//   out     | out_valid_o / out_ready_i  | out_data_o (rrd_out_t)
//
// one word enters per cycle while the two-entry output buffer has room
// the pipeline holds the 29-stage cos_t divider, the 15- and 31-stage square roots
// and the 16-stage component divider, plus the arithmetic and normalize stages
// the whole pipeline advances together while the two-entry output buffer has room
// reset clears the valid bits and the output buffer; no clearing pass
module reflect_refract_direction_unit
  import rrd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  rrd_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output rrd_out_t out_data_o
);

  logic en;
  logic [1:0] cnt_q;

  assign en         = (cnt_q != 2'd2);
  assign in_ready_o = en;

  // ---------------- stage 1: component products of N.I
  logic [2:0][15:0] in_nv, in_iv;
  logic [2:0][31:0] in_p;
  assign in_nv = {in_data_i.normal_z, in_data_i.normal_y, in_data_i.normal_x};
  assign in_iv = {in_data_i.incident_z, in_data_i.incident_y, in_data_i.incident_x};

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_p[k] = $signed(in_nv[k]) * $signed(in_iv[k]);
    end
  end

  logic s1_v_q, s1_op_q, s1_same_q, s1_tozero_q;
  logic [2:0][15:0] s1_nv_q, s1_iv_q;
  logic [2:0][31:0] s1_p_q;
  logic [15:0] s1_from_q, s1_to_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_op_q     <= in_data_i.opcode;
      s1_nv_q     <= in_nv;
      s1_iv_q     <= in_iv;
      s1_p_q      <= in_p;
      s1_from_q   <= in_data_i.index_from;
      s1_to_q     <= in_data_i.index_to;
      s1_same_q   <= (in_data_i.index_from == in_data_i.index_to);
      s1_tozero_q <= (in_data_i.index_to == 16'd0);
    end
  end

  // ---------------- stage 2: round N.I, index squares
  logic signed [33:0] s2_draw;
  logic [33:0] s2_dmag;
  logic [19:0] s2_dqm;
  logic signed [20:0] s2_dq;

  always_comb begin
    s2_draw = 34'($signed(s1_p_q[0])) + 34'($signed(s1_p_q[1]))
            + 34'($signed(s1_p_q[2]));
    s2_dmag = s2_draw[33] ? 34'(-s2_draw) : 34'(s2_draw);
    s2_dqm  = 20'((s2_dmag + 34'(HALF)) >> FRAC_BITS);
    s2_dq   = s2_draw[33] ? -$signed({1'b0, s2_dqm}) : $signed({1'b0, s2_dqm});
  end

  logic s2_v_q, s2_op_q, s2_same_q, s2_tozero_q;
  logic [2:0][15:0] s2_nv_q, s2_iv_q;
  logic [15:0] s2_from_q, s2_to_q;
  logic [20:0] s2_dq_q;
  logic [31:0] s2_from2_q, s2_to2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_op_q     <= s1_op_q;
      s2_same_q   <= s1_same_q;
      s2_tozero_q <= s1_tozero_q;
      s2_nv_q     <= s1_nv_q;
      s2_iv_q     <= s1_iv_q;
      s2_from_q   <= s1_from_q;
      s2_to_q     <= s1_to_q;
      s2_dq_q     <= s2_dq;
      s2_from2_q  <= s1_from_q * s1_from_q;
      s2_to2_q    <= s1_to_q * s1_to_q;
    end
  end

  // ---------------- stage 3: clamp d, d^2, reflect products
  logic signed [20:0] s3_dqs;
  logic signed [15:0] s3_dc;
  logic [14:0] s3_dcm;
  logic [2:0][36:0] s3_rp;

  always_comb begin
    s3_dqs = $signed(s2_dq_q);
    if (s3_dqs > $signed(21'(ONE))) begin
      s3_dc = 16'(ONE);
    end else if (s3_dqs < -$signed(21'(ONE))) begin
      s3_dc = -$signed(16'(ONE));
    end else begin
      s3_dc = 16'(s3_dqs);
    end
    s3_dcm = s3_dc[15] ? 15'(-s3_dc) : 15'(s3_dc);
    for (int k = 0; k < 3; k++) begin
      s3_rp[k] = s3_dqs * $signed(s2_nv_q[k]);
    end
  end

  logic s3_v_q, s3_op_q, s3_same_q, s3_tozero_q;
  logic [2:0][15:0] s3_nv_q, s3_iv_q;
  logic [15:0] s3_from_q, s3_to_q, s3_dc_q;
  logic [29:0] s3_dcsq_q;
  logic [31:0] s3_from2_q, s3_to2_q;
  logic [2:0][36:0] s3_rp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_op_q     <= s2_op_q;
      s3_same_q   <= s2_same_q;
      s3_tozero_q <= s2_tozero_q;
      s3_nv_q     <= s2_nv_q;
      s3_iv_q     <= s2_iv_q;
      s3_from_q   <= s2_from_q;
      s3_to_q     <= s2_to_q;
      s3_dc_q     <= s3_dc;
      s3_dcsq_q   <= s3_dcm * s3_dcm;
      s3_from2_q  <= s2_from2_q;
      s3_to2_q    <= s2_to2_q;
      s3_rp_q     <= s3_rp;
    end
  end

  // ---------------- stage 4: 1 - d^2, reflect vector
  logic [14:0] s4_kq;
  logic [2:0][RVEC_W-1:0] s4_rvec;

  always_comb begin
    s4_kq = 15'(ONE) - 15'((s3_dcsq_q + 30'(HALF)) >> FRAC_BITS);
    for (int k = 0; k < 3; k++) begin
      s4_rvec[k] = (RVEC_W'($signed(s3_iv_q[k])) <<< FRAC_BITS)
                 - (RVEC_W'($signed(s3_rp_q[k])) <<< 1);
    end
  end

  logic s4_v_q, s4_op_q, s4_same_q, s4_tozero_q;
  logic [2:0][15:0] s4_nv_q, s4_iv_q;
  logic [15:0] s4_from_q, s4_to_q, s4_dc_q;
  logic [14:0] s4_kq_q;
  logic [31:0] s4_from2_q, s4_to2_q;
  logic [2:0][RVEC_W-1:0] s4_rvec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (en) begin
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_op_q     <= s3_op_q;
      s4_same_q   <= s3_same_q;
      s4_tozero_q <= s3_tozero_q;
      s4_nv_q     <= s3_nv_q;
      s4_iv_q     <= s3_iv_q;
      s4_from_q   <= s3_from_q;
      s4_to_q     <= s3_to_q;
      s4_dc_q     <= s3_dc_q;
      s4_kq_q     <= s4_kq;
      s4_from2_q  <= s3_from2_q;
      s4_to2_q    <= s3_to2_q;
      s4_rvec_q   <= s4_rvec;
    end
  end

  // ---------------- stage 5: from^2 (1 - d^2), to^2 carried along for the comparison
  logic s5_v_q, s5_op_q, s5_same_q, s5_tozero_q;
  logic [2:0][15:0] s5_nv_q, s5_iv_q;
  logic [15:0] s5_from_q, s5_to_q, s5_dc_q;
  logic [46:0] s5_lhs_q;
  logic [31:0] s5_to2_q;
  logic [2:0][RVEC_W-1:0] s5_rvec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_v_q <= 1'b0;
    end else if (en) begin
      s5_v_q <= s4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s5_op_q     <= s4_op_q;
      s5_same_q   <= s4_same_q;
      s5_tozero_q <= s4_tozero_q;
      s5_nv_q     <= s4_nv_q;
      s5_iv_q     <= s4_iv_q;
      s5_from_q   <= s4_from_q;
      s5_to_q     <= s4_to_q;
      s5_dc_q     <= s4_dc_q;
      s5_lhs_q    <= 47'(s4_from2_q) * 47'(s4_kq_q);
      s5_to2_q    <= s4_to2_q;
      s5_rvec_q   <= s4_rvec_q;
    end
  end

  // ---------------- total internal reflection test, mode, cos_t^2 quotient
  localparam int unsigned CQ_W = 2 * FRAC_BITS + 1;
  logic [46:0] s6_rhs;
  logic [45:0] s6_num;
  logic s6_tir;
  mode_e s6_mode;
  cos_side_t s6_side, dv_side, cs_side;
  logic [31+CQ_W:0] s6_div_num;
  logic dv_v, cs_v;
  logic [CQ_W-1:0] dv_quo;
  logic [FRAC_BITS:0] cs_root;

  always_comb begin
    s6_rhs = 47'(s5_to2_q) << FRAC_BITS;
    s6_tir = (s5_lhs_q > s6_rhs);
    s6_num = 46'(s6_rhs - s5_lhs_q);
    s6_div_num = (32 + CQ_W)'(s6_num) << FRAC_BITS;
    if (s5_op_q == opcode_reflect) begin
      s6_mode = MODE_VEC;
    end else if (s5_same_q) begin
      s6_mode = MODE_PASS;
    end else if (s5_tozero_q || s6_tir) begin
      s6_mode = MODE_TIR;
    end else begin
      s6_mode = MODE_VEC;
    end
    s6_side.mode   = s6_mode;
    s6_side.opcode = s5_op_q;
    s6_side.nv     = s5_nv_q;
    s6_side.iv     = s5_iv_q;
    s6_side.from   = s5_from_q;
    s6_side.to     = s5_to_q;
    s6_side.dc     = s5_dc_q;
    s6_side.rvec   = s5_rvec_q;
  end

  rrd_div_pipe #(
    .LANES  (1),
    .DEN_W  (32),
    .QUO_W  (CQ_W),
    .SIDE_W ($bits(cos_side_t))
  ) u_cos_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s5_v_q),
    .num_i   (s6_div_num),
    .den_i   (s5_to2_q),
    .side_i  (s6_side),
    .valid_o (dv_v),
    .quo_o   (dv_quo),
    .side_o  (dv_side)
  );

  rrd_sqrt_pipe #(
    .X_W    (CQ_W + 1),
    .SIDE_W ($bits(cos_side_t))
  ) u_cos_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (dv_v),
    .x_i     ({1'b0, dv_quo}),
    .side_i  (dv_side),
    .valid_o (cs_v),
    .root_o  (cs_root),
    .side_o  (cs_side)
  );

  // ---------------- stage 7: normal coefficient, scaled incident
  logic signed [32:0] s7_fd;
  logic [30:0] s7_tc;
  logic signed [33:0] s7_bcoef;
  logic [2:0][32:0] s7_fi;

  always_comb begin
    s7_fd    = $signed({1'b0, cs_side.from}) * $signed(cs_side.dc);
    s7_tc    = cs_side.to * cs_root;
    s7_bcoef = 34'(s7_fd) + 34'(s7_tc);
    for (int k = 0; k < 3; k++) begin
      s7_fi[k] = $signed({1'b0, cs_side.from}) * $signed(cs_side.iv[k]);
    end
  end

  logic s7_v_q, s7_op_q;
  mode_e s7_mode_q;
  logic [2:0][15:0] s7_nv_q, s7_iv_q;
  logic [33:0] s7_bcoef_q;
  logic [2:0][32:0] s7_fi_q;
  logic [2:0][RVEC_W-1:0] s7_rvec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_v_q <= 1'b0;
    end else if (en) begin
      s7_v_q <= cs_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s7_op_q    <= cs_side.opcode;
      s7_mode_q  <= cs_side.mode;
      s7_nv_q    <= cs_side.nv;
      s7_iv_q    <= cs_side.iv;
      s7_bcoef_q <= s7_bcoef;
      s7_fi_q    <= s7_fi;
      s7_rvec_q  <= cs_side.rvec;
    end
  end

  // ---------------- stage 8: refract vector, pick by opcode
  logic [2:0][VEC_W-1:0] s8_vec;
  logic signed [VEC_W-1:0] s8_t1, s8_t2;

  always_comb begin
    s8_t1 = '0;
    s8_t2 = '0;
    for (int k = 0; k < 3; k++) begin
      s8_t1 = VEC_W'($signed(s7_fi_q[k])) <<< FRAC_BITS;
      s8_t2 = $signed(s7_bcoef_q) * $signed(s7_nv_q[k]);
      if (s7_op_q == opcode_refract) begin
        s8_vec[k] = s8_t1 - s8_t2;
      end else begin
        s8_vec[k] = VEC_W'($signed(s7_rvec_q[k]));
      end
    end
  end

  logic s8_v_q;
  mode_e s8_mode_q;
  logic [2:0][15:0] s8_iv_q;
  logic [2:0][VEC_W-1:0] s8_vec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_v_q <= 1'b0;
    end else if (en) begin
      s8_v_q <= s7_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s8_mode_q <= s7_mode_q;
      s8_iv_q   <= s7_iv_q;
      s8_vec_q  <= s8_vec;
    end
  end

  // ---------------- normalize 1: magnitudes and signs
  logic [2:0][VEC_W-1:0] n1_mag;
  logic [2:0] n1_neg;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      n1_neg[k] = s8_vec_q[k][VEC_W-1];
      n1_mag[k] = n1_neg[k] ? VEC_W'(-$signed(s8_vec_q[k])) : s8_vec_q[k];
    end
  end

  logic n1_v_q;
  mode_e n1_mode_q;
  logic [2:0][15:0] n1_iv_q;
  logic [2:0][VEC_W-1:0] n1_mag_q;
  logic [2:0] n1_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n1_v_q <= 1'b0;
    end else if (en) begin
      n1_v_q <= s8_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n1_mode_q <= s8_mode_q;
      n1_iv_q   <= s8_iv_q;
      n1_mag_q  <= n1_mag;
      n1_neg_q  <= n1_neg;
    end
  end

  // ---------------- normalize 2: leading one of the largest magnitude
  // the top set bit of the OR of the magnitudes is the top bit of the max
  logic [VEC_W-1:0] n2_or;
  logic [POS_W-1:0] n2_pos;

  always_comb begin
    n2_or  = n1_mag_q[0] | n1_mag_q[1] | n1_mag_q[2];
    n2_pos = '0;
    for (int b = 0; b < VEC_W; b++) begin
      if (n2_or[b]) begin
        n2_pos = POS_W'(b);
      end
    end
  end

  logic n2_v_q, n2_zero_q;
  mode_e n2_mode_q;
  logic [2:0][15:0] n2_iv_q;
  logic [2:0][VEC_W-1:0] n2_mag_q;
  logic [2:0] n2_neg_q;
  logic [POS_W-1:0] n2_pos_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n2_v_q <= 1'b0;
    end else if (en) begin
      n2_v_q <= n1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n2_mode_q <= n1_mode_q;
      n2_iv_q   <= n1_iv_q;
      n2_mag_q  <= n1_mag_q;
      n2_neg_q  <= n1_neg_q;
      n2_pos_q  <= n2_pos;
      n2_zero_q <= (n2_or == '0);
    end
  end

  // ---------------- normalize 3: shift max into [2^29, 2^30)
  logic [2:0][NRM_W-1:0] n3_m;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (n2_pos_q >= POS_W'(NRM_MSB)) begin
        n3_m[k] = NRM_W'(n2_mag_q[k] >> (n2_pos_q - POS_W'(NRM_MSB)));
      end else begin
        n3_m[k] = NRM_W'(n2_mag_q[k] << (POS_W'(NRM_MSB) - n2_pos_q));
      end
    end
  end

  logic n3_v_q, n3_zero_q;
  mode_e n3_mode_q;
  logic [2:0][15:0] n3_iv_q;
  logic [2:0][NRM_W-1:0] n3_m_q;
  logic [2:0] n3_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n3_v_q <= 1'b0;
    end else if (en) begin
      n3_v_q <= n2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n3_mode_q <= n2_mode_q;
      n3_iv_q   <= n2_iv_q;
      n3_m_q    <= n3_m;
      n3_neg_q  <= n2_neg_q;
      n3_zero_q <= n2_zero_q;
    end
  end

  // ---------------- normalize 4: squares
  logic n4_v_q, n4_zero_q;
  mode_e n4_mode_q;
  logic [2:0][15:0] n4_iv_q;
  logic [2:0][NRM_W-1:0] n4_m_q;
  logic [2:0][2*NRM_W-1:0] n4_sq_q;
  logic [2:0] n4_neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n4_v_q <= 1'b0;
    end else if (en) begin
      n4_v_q <= n3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n4_mode_q <= n3_mode_q;
      n4_iv_q   <= n3_iv_q;
      n4_m_q    <= n3_m_q;
      n4_neg_q  <= n3_neg_q;
      n4_zero_q <= n3_zero_q;
      for (int k = 0; k < 3; k++) begin
        n4_sq_q[k] <= n3_m_q[k] * n3_m_q[k];
      end
    end
  end

  // ---------------- normalize 5: sum of squares
  localparam int unsigned SS_W = 2 * NRM_W + 2;

  logic n5_v_q;
  logic [SS_W-1:0] n5_ss_q;
  nrm_side_t n5_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n5_v_q <= 1'b0;
    end else if (en) begin
      n5_v_q <= n4_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      n5_ss_q        <= SS_W'(n4_sq_q[0]) + SS_W'(n4_sq_q[1]) + SS_W'(n4_sq_q[2]);
      n5_side_q.mode <= n4_mode_q;
      n5_side_q.iv   <= n4_iv_q;
      n5_side_q.neg  <= n4_neg_q;
      n5_side_q.zero <= n4_zero_q;
      n5_side_q.m    <= n4_m_q;
    end
  end

  // ---------------- length, then one divider lane per component
  localparam int unsigned LEN_W = SS_W / 2;
  localparam int unsigned Q_W   = 16;

  logic ln_v, qd_v;
  logic [LEN_W-1:0] ln_len;
  nrm_side_t ln_side, qd_side;
  logic [2:0][LEN_W+Q_W-1:0] ln_num;
  logic [2:0][Q_W-1:0] qd_quo;

  rrd_sqrt_pipe #(
    .X_W    (SS_W),
    .SIDE_W ($bits(nrm_side_t))
  ) u_len_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (n5_v_q),
    .x_i     (n5_ss_q),
    .side_i  (n5_side_q),
    .valid_o (ln_v),
    .root_o  (ln_len),
    .side_o  (ln_side)
  );

  // round half up: (m * ONE + len / 2) / len
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ln_num[k] = ((LEN_W + Q_W)'(ln_side.m[k]) << FRAC_BITS)
                + (LEN_W + Q_W)'(ln_len >> 1);
    end
  end

  rrd_div_pipe #(
    .LANES  (3),
    .DEN_W  (LEN_W),
    .QUO_W  (Q_W),
    .SIDE_W ($bits(nrm_side_t))
  ) u_comp_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ln_v),
    .num_i   (ln_num),
    .den_i   (ln_len),
    .side_i  (ln_side),
    .valid_o (qd_v),
    .quo_o   (qd_quo),
    .side_o  (qd_side)
  );

  // ---------------- final word assembly
  rrd_out_t fin;
  logic [2:0][15:0] fin_c;
  logic signed [16:0] fin_s;

  always_comb begin
    fin_s = '0;
    for (int k = 0; k < 3; k++) begin
      fin_s    = qd_side.neg[k] ? -$signed({1'b0, qd_quo[k]}) : $signed({1'b0, qd_quo[k]});
      fin_c[k] = qd_side.zero ? 16'd0 : sat16(fin_s);
    end
    unique case (qd_side.mode)
      MODE_PASS: begin
        fin.out_x     = qd_side.iv[0];
        fin.out_y     = qd_side.iv[1];
        fin.out_z     = qd_side.iv[2];
        fin.ray_valid = 1'b1;
      end
      MODE_VEC: begin
        fin.out_x     = fin_c[0];
        fin.out_y     = fin_c[1];
        fin.out_z     = fin_c[2];
        fin.ray_valid = 1'b1;
      end
      default: begin
        fin.out_x     = '0;
        fin.out_y     = '0;
        fin.out_z     = '0;
        fin.ray_valid = 1'b0;
      end
    endcase
  end

  // ---------------- two-entry output buffer
  logic push, pop;
  logic wr_ptr_q, rd_ptr_q;
  rrd_out_t buf_q [2];

  assign push = en && qd_v;
  assign pop  = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= fin;
    end
  end

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_data_o  = buf_q[rd_ptr_q];

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("output buffer count out of range");

  a_tir_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.ray_valid |->
      out_data_o.out_x == 16'd0 && out_data_o.out_y == 16'd0 && out_data_o.out_z == 16'd0)
    else $error("no-ray word carries a nonzero vector");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("output buffer lost a word");

  a_stall_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en && qd_v |=> qd_v && $stable(qd_quo))
    else $error("pipeline tail changed while stalled");
`endif

endmodule

### rtl/core/rrd_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage, lanes share the divisor
module rrd_div_pipe #(
  parameter int unsigned LANES  = 1,
  parameter int unsigned DEN_W  = 32,
  parameter int unsigned QUO_W  = 16,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  logic [LANES-1:0][DEN_W+QUO_W-1:0]     num_i,
  input  logic [DEN_W-1:0]                      den_i,
  input  logic [SIDE_W-1:0]                     side_i,
  output logic                                  valid_o,
  output logic [LANES-1:0][QUO_W-1:0]           quo_o,
  output logic [SIDE_W-1:0]                     side_o
);

  localparam int unsigned REM_W = DEN_W + QUO_W;

  logic [LANES-1:0][REM_W-1:0] rem_q  [QUO_W];
  logic [LANES-1:0][QUO_W-1:0] quo_q  [QUO_W];
  logic [DEN_W-1:0]            den_q  [QUO_W];
  logic [SIDE_W-1:0]           side_q [QUO_W];
  logic [QUO_W-1:0]            valid_q;

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    localparam int unsigned SH = QUO_W - 1 - i;
    logic [LANES-1:0][REM_W-1:0] rem_in, rem_d;
    logic [LANES-1:0][QUO_W-1:0] quo_in, quo_d;
    logic [DEN_W-1:0]            den_in;
    logic [SIDE_W-1:0]           side_in;
    logic                        valid_in;
    logic [REM_W-1:0]            trial;

    if (i == 0) begin : g_first
      assign rem_in   = num_i;
      assign quo_in   = '0;
      assign den_in   = den_i;
      assign side_in  = side_i;
      assign valid_in = valid_i;
    end else begin : g_next
      assign rem_in   = rem_q[i-1];
      assign quo_in   = quo_q[i-1];
      assign den_in   = den_q[i-1];
      assign side_in  = side_q[i-1];
      assign valid_in = valid_q[i-1];
    end

    assign trial = REM_W'(den_in) << SH;

    always_comb begin
      rem_d = rem_in;
      quo_d = quo_in;
      for (int l = 0; l < LANES; l++) begin
        if (rem_in[l] >= trial) begin
          rem_d[l]     = rem_in[l] - trial;
          quo_d[l][SH] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (en_i) begin
        valid_q[i] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= rem_d;
        quo_q[i]  <= quo_d;
        den_q[i]  <= den_in;
        side_q[i] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[QUO_W-1];
  assign quo_o   = quo_q[QUO_W-1];
  assign side_o  = side_q[QUO_W-1];

endmodule

### rtl/core/rrd_sqrt_pipe.sv
// pipelined integer square root (floor), one root bit per stage
module rrd_sqrt_pipe #(
  parameter int unsigned X_W    = 30,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [X_W-1:0]       x_i,
  input  logic [SIDE_W-1:0]    side_i,
  output logic                 valid_o,
  output logic [X_W/2-1:0]     root_o,
  output logic [SIDE_W-1:0]    side_o
);

  localparam int unsigned RT_W = X_W / 2;
  localparam int unsigned W    = X_W + 1;

  logic [W-1:0]      rem_q  [RT_W];
  logic [W-1:0]      r_q    [RT_W];
  logic [SIDE_W-1:0] side_q [RT_W];
  logic [RT_W-1:0]   valid_q;

  for (genvar i = 0; i < RT_W; i++) begin : g_stage
    localparam int unsigned J = RT_W - 1 - i;
    logic [W-1:0]      rem_in, r_in, rem_d, r_d, bit_v, rb;
    logic [SIDE_W-1:0] side_in;
    logic              valid_in;

    if (i == 0) begin : g_first
      assign rem_in   = W'(x_i);
      assign r_in     = '0;
      assign side_in  = side_i;
      assign valid_in = valid_i;
    end else begin : g_next
      assign rem_in   = rem_q[i-1];
      assign r_in     = r_q[i-1];
      assign side_in  = side_q[i-1];
      assign valid_in = valid_q[i-1];
    end

    assign bit_v = W'(1) << (2 * J);
    assign rb    = r_in + bit_v;

    always_comb begin
      if (rem_in >= rb) begin
        rem_d = rem_in - rb;
        r_d   = (r_in >> 1) + bit_v;
      end else begin
        rem_d = rem_in;
        r_d   = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (en_i) begin
        valid_q[i] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= rem_d;
        r_q[i]    <= r_d;
        side_q[i] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[RT_W-1];
  assign root_o  = r_q[RT_W-1][RT_W-1:0];
  assign side_o  = side_q[RT_W-1];

endmodule
